// ===== rtl/tsb_pkg.sv =====
// Shared constants for the timer slot bank: operation and result codes, data widths.
`timescale 1ns / 1ps
package tsb_pkg;

  localparam int TL_W = 32;  // signed time left of a slot
  localparam int RI_W = 24;  // reload interval of a slot
  localparam int EL_W = 16;  // elapsed time of a tick

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  localparam logic [2:0] K_FIRED    = 3'd0;
  localparam logic [2:0] K_DONE     = 3'd1;
  localparam logic [2:0] K_SET_OK   = 3'd2;
  localparam logic [2:0] K_SET_FULL = 3'd3;
  localparam logic [2:0] K_CAN_OK   = 3'd4;
  localparam logic [2:0] K_CAN_MISS = 3'd5;

endpackage

// ===== rtl/tsb_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module tsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tsb_alu.sv =====
// Shared saturating add/subtract unit for the time left of a slot.
`timescale 1ns / 1ps
module tsb_alu
  import tsb_pkg::*;
(
  input  logic [TL_W-1:0] a,    // signed operand
  input  logic [TL_W-1:0] b,    // non-negative operand
  input  logic            sub,
  output logic [TL_W-1:0] y
);

  logic [TL_W:0] a_ext;
  logic [TL_W:0] b_ext;
  logic [TL_W:0] sum;

  assign a_ext = {a[TL_W-1], a};
  assign b_ext = {1'b0, b};
  assign sum   = sub ? (a_ext - b_ext) : (a_ext + b_ext);

  // The 33-bit result is exact; clamp when it leaves the 32-bit signed range.
  always_comb begin
    if (sum[TL_W] != sum[TL_W-1]) begin
      y = sum[TL_W] ? {1'b1, {(TL_W-1){1'b0}}} : {1'b0, {(TL_W-1){1'b1}}};
    end else begin
      y = sum[TL_W-1:0];
    end
  end

endmodule

// ===== rtl/timer_slot_bank_top.sv =====
// Top level of the timer slot bank: sequencer, slot flags, slot RAMs and result register.
`timescale 1ns / 1ps
//
// Channel | Handshake           | Payload
// --------+---------------------+---------------------------------------------------
// input   | in_valid / in_ready | op, elapsed_ms, first_delay_ms, interval_ms,
//         |                     | loop_flag, slot_id
// output  | out_valid/out_ready | kind, slot, last
//
// A tick walks the slots in order: a free slot passes the scan state only, an active
// slot that does not fire also the subtract state, a fired one-shot also the fire
// state, a fired looping slot also the reload state; then the result state gives the
// done marker. The shared saturating adder and the single read port of the slot RAMs
// set these steps. A set scans for the lowest free slot. Reset clears the active and
// looping flags, the sequencer and the output valid flag; the RAMs are not cleared.
// Only the fire and result states wait for a stalled output until the transfer is taken.
module timer_slot_bank_top
  import tsb_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] elapsed_ms,
  input  logic [23:0] first_delay_ms,
  input  logic [23:0] interval_ms,
  input  logic        loop_flag,
  input  logic [3:0]  slot_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [3:0]  slot,
  output logic        last
);

  // Index width for the slot RAMs and flags, and a counter wide enough to reach SLOTS.
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] SLOTS_C = IW'(SLOTS);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TSCAN  = 3'd1;  // tick: look at the slot under idx
  localparam logic [2:0] ST_TSUB   = 3'd2;  // tick: subtract elapsed time
  localparam logic [2:0] ST_TFIRE  = 3'd3;  // tick: report a fired slot
  localparam logic [2:0] ST_TADD   = 3'd4;  // tick: reload a looping slot
  localparam logic [2:0] ST_SSCAN  = 3'd5;  // set: search for the lowest free slot
  localparam logic [2:0] ST_CANCEL = 3'd6;
  localparam logic [2:0] ST_RESP   = 3'd7;  // final result of the item

  // Control registers.
  logic [2:0]       state, state_next;
  logic [IW-1:0]    idx, idx_next;
  logic [SLOTS-1:0] active, active_next;
  logic [SLOTS-1:0] looping, looping_next;

  // Latched item fields and working registers.
  logic [EL_W-1:0]  elapsed_q;
  logic [23:0]      first_q;
  logic [RI_W-1:0]  interval_q;
  logic             loop_q;
  logic [3:0]       sid_q;
  logic [TL_W-1:0]  acc, acc_next;
  logic [2:0]       res_kind, res_kind_next;
  logic [3:0]       res_slot, res_slot_next;

  // Result register.
  logic             emit;
  logic [2:0]       emit_kind;
  logic [3:0]       emit_slot;
  logic             emit_last;
  logic             can_emit;

  // Slot RAM and shared unit signals.
  logic [AW-1:0]    idx_ix;
  logic [AW-1:0]    sid_ix;
  logic             sid_ok;
  logic             tl_we;
  logic [TL_W-1:0]  tl_wdata;
  logic [TL_W-1:0]  tl_rdata;
  logic             ri_we;
  logic [RI_W-1:0]  ri_rdata;
  logic [TL_W-1:0]  alu_a;
  logic [TL_W-1:0]  alu_b;
  logic             alu_sub;
  logic [TL_W-1:0]  alu_y;
  logic             fired;
  logic             in_xfer;

  assign idx_ix   = idx[AW-1:0];
  assign sid_ix   = AW'(sid_q);
  assign sid_ok   = ({3'b000, sid_q} < 7'(SLOTS));
  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // The result register can take a new result when it is empty or being drained.
  assign can_emit = !out_valid || out_ready;

  // A slot fires when its time left reaches zero or goes below it.
  assign fired = alu_y[TL_W-1] || (alu_y == '0);

  // Time left of each slot. It is read at idx every cycle, so the data for the slot
  // under idx is ready in the cycle after the sequencer arrives there.
  tsb_ram #(
    .WIDTH(TL_W),
    .DEPTH(SLOTS)
  ) u_time_left (
    .clk  (clk),
    .we   (tl_we),
    .waddr(idx_ix),
    .wdata(tl_wdata),
    .raddr(idx_ix),
    .rdata(tl_rdata)
  );

  // Reload interval of each slot.
  tsb_ram #(
    .WIDTH(RI_W),
    .DEPTH(SLOTS)
  ) u_reload (
    .clk  (clk),
    .we   (ri_we),
    .waddr(idx_ix),
    .wdata(interval_q),
    .raddr(idx_ix),
    .rdata(ri_rdata)
  );

  // One saturating adder serves both the tick subtraction and the reload addition.
  tsb_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .sub(alu_sub),
    .y  (alu_y)
  );

  always_comb begin
    if (state == ST_TADD) begin
      alu_a   = acc;
      alu_b   = {{(TL_W-RI_W){1'b0}}, ri_rdata};
      alu_sub = 1'b0;
    end else begin
      alu_a   = tl_rdata;
      alu_b   = {{(TL_W-EL_W){1'b0}}, elapsed_q};
      alu_sub = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    active_next   = active;
    looping_next  = looping;
    acc_next      = acc;
    res_kind_next = res_kind;
    res_slot_next = res_slot;
    emit          = 1'b0;
    emit_kind     = res_kind;
    emit_slot     = res_slot;
    emit_last     = 1'b1;
    tl_we         = 1'b0;
    tl_wdata      = alu_y;
    ri_we         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_next = '0;
          case (op)
            OP_TICK:   state_next = ST_TSCAN;
            OP_SET:    state_next = ST_SSCAN;
            OP_CANCEL: state_next = ST_CANCEL;
            default:   state_next = ST_IDLE;  // unused code: no result
          endcase
        end
      end

      ST_TSCAN: begin
        if (idx == SLOTS_C) begin
          res_kind_next = K_DONE;
          res_slot_next = '0;
          state_next    = ST_RESP;
        end else if (active[idx_ix]) begin
          state_next = ST_TSUB;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      ST_TSUB: begin
        acc_next = alu_y;
        if (fired) begin
          state_next = ST_TFIRE;
        end else begin
          tl_we      = 1'b1;
          idx_next   = idx + 1'b1;
          state_next = ST_TSCAN;
        end
      end

      ST_TFIRE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_kind = K_FIRED;
          emit_slot = 4'(idx);
          emit_last = 1'b0;
          if (looping[idx_ix]) begin
            state_next = ST_TADD;
          end else begin
            // A one-shot slot is freed; its stored time left is not used again until a set rewrites it.
            active_next[idx_ix] = 1'b0;
            idx_next            = idx + 1'b1;
            state_next          = ST_TSCAN;
          end
        end
      end

      ST_TADD: begin
        tl_we      = 1'b1;
        idx_next   = idx + 1'b1;
        state_next = ST_TSCAN;
      end

      ST_SSCAN: begin
        if (idx == SLOTS_C) begin
          res_kind_next = K_SET_FULL;
          res_slot_next = '0;
          state_next    = ST_RESP;
        end else if (!active[idx_ix]) begin
          tl_we                = 1'b1;
          tl_wdata             = {{(TL_W-24){1'b0}}, first_q};
          ri_we                = 1'b1;
          active_next[idx_ix]  = 1'b1;
          looping_next[idx_ix] = loop_q;
          res_kind_next        = K_SET_OK;
          res_slot_next        = 4'(idx);
          state_next           = ST_RESP;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      ST_CANCEL: begin
        res_slot_next = sid_q;
        if (sid_ok && active[sid_ix]) begin
          active_next[sid_ix] = 1'b0;
          res_kind_next       = K_CAN_OK;
        end else begin
          res_kind_next = K_CAN_MISS;
        end
        state_next = ST_RESP;
      end

      ST_RESP: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      active    <= '0;
      looping   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      active  <= active_next;
      looping <= looping_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      elapsed_q  <= elapsed_ms;
      first_q    <= first_delay_ms;
      interval_q <= interval_ms;
      loop_q     <= loop_flag;
      sid_q      <= slot_id;
    end
    acc      <= acc_next;
    res_kind <= res_kind_next;
    res_slot <= res_slot_next;
    if (emit) begin
      kind <= emit_kind;
      slot <= emit_slot;
      last <= emit_last;
    end
  end

endmodule

// ===== tb/sv/tsb_tracker_pkg.sv =====
// Result tracker for the timer slot bank: slot state, expected result queue and checks.
`timescale 1ns / 1ps
package tsb_tracker_pkg;
  import tsb_pkg::*;

  localparam int SLOT_COUNT = 16;
  localparam longint TL_MIN = -64'sd2147483648;
  localparam longint TL_MAX = 64'sd2147483647;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic       last;
  } bank_result_t;

  class slot_bank_tracker;
    bank_result_t due_results[$];
    bit active[SLOT_COUNT];
    bit looping[SLOT_COUNT];
    logic signed [TL_W-1:0] time_left[SLOT_COUNT];
    logic [RI_W-1:0] reload[SLOT_COUNT];
    int errors;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        active[i] = 1'b0;
        looping[i] = 1'b0;
        time_left[i] = '0;
        reload[i] = '0;
      end
      errors = 0;
    endfunction

    function automatic logic signed [TL_W-1:0] clamp_ms(longint v);
      if (v < TL_MIN) return TL_MIN[TL_W-1:0];
      if (v > TL_MAX) return TL_MAX[TL_W-1:0];
      return v[TL_W-1:0];
    endfunction

    function void push_result(logic [2:0] kind, logic [3:0] slot, logic last);
      bank_result_t r;
      r.kind = kind;
      r.slot = slot;
      r.last = last;
      due_results.insert(due_results.size(), r);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Advances the slot state by one accepted item and queues what it causes.
    function void apply_item(logic [1:0] op, logic [EL_W-1:0] elapsed,
                             logic [23:0] first_delay, logic [RI_W-1:0] interval,
                             logic loop_flag, logic [3:0] slot_id);
      bit placed;
      placed = 1'b0;
      case (op)
        OP_TICK: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (active[i]) begin
              time_left[i] = clamp_ms(longint'(time_left[i]) - longint'(elapsed));
              if (time_left[i] <= 0) begin
                push_result(K_FIRED, i[3:0], 1'b0);
                if (looping[i])
                  time_left[i] = clamp_ms(longint'(time_left[i]) + longint'(reload[i]));
                else
                  active[i] = 1'b0;
              end
            end
          end
          push_result(K_DONE, 4'd0, 1'b1);
        end
        OP_SET: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!placed && !active[i]) begin
              placed = 1'b1;
              active[i] = 1'b1;
              looping[i] = loop_flag;
              time_left[i] = {8'd0, first_delay};
              reload[i] = interval;
              push_result(K_SET_OK, i[3:0], 1'b1);
            end
          end
          if (!placed) push_result(K_SET_FULL, 4'd0, 1'b1);
        end
        OP_CANCEL: begin
          if (int'(slot_id) < SLOT_COUNT && active[slot_id]) begin
            active[slot_id] = 1'b0;
            push_result(K_CAN_OK, slot_id, 1'b1);
          end else begin
            push_result(K_CAN_MISS, slot_id, 1'b1);
          end
        end
        default: begin
          // The unused code leaves the bank untouched.
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task match_result(logic [2:0] kind, logic [3:0] slot, logic last);
      bank_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d slot %0d last %0d",
                                  kind, slot, last));
      end else begin
        want = due_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
        if (slot !== want.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
        if (last !== want.last)
          report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
      end
    endtask
  endclass

endpackage

// ===== tb/sv/tb_timer_slot_bank_top.sv =====
// Testbench top for the timer slot bank: clock, reset, stimulus, idling and result checks.
`timescale 1ns / 1ps
module tb_timer_slot_bank_top;
  import tsb_pkg::*;
  import tsb_tracker_pkg::*;

  // The unused operation code; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // A generous cycle budget, several times the slowest correct run.
  localparam int CYCLE_LIMIT = 5_000_000;
  // A few more ticks of the largest elapsed time with the zero-interval slot running.
  localparam int REPEAT_TICKS = 4;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int MAX_GAP = 40;
  // Longest walk of a tick through all slots plus the done marker, with margin.
  localparam int SETTLE_CYCLES = 100;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_TICK;
  logic [15:0] elapsed_ms = '0;
  logic [23:0] first_delay_ms = '0;
  logic [23:0] interval_ms = '0;
  logic        loop_flag = 1'b0;
  logic [3:0]  slot_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic        last;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;
  // While set, the receiver refuses every transfer so the bank backs up.
  logic hold_active = 1'b0;
  int cycle_count = 0;

  slot_bank_tracker bank = new();

  timer_slot_bank_top #(
    .SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .elapsed_ms    (elapsed_ms),
    .first_delay_ms(first_delay_ms),
    .interval_ms   (interval_ms),
    .loop_flag     (loop_flag),
    .slot_id       (slot_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .slot          (slot),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off if it overruns the budget; a hung block ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: ready is drawn fresh every cycle unless a hold-off is running.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end
  end

  // Both channels are observed at the clock edge, with the values the block itself saw.
  // An input transfer updates the predicted slot state; an output transfer is checked
  // against the oldest result still due.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      bank.apply_item(op, elapsed_ms, first_delay_ms, interval_ms, loop_flag, slot_id);
    end
    if (!rst && out_valid && out_ready) begin
      bank.match_result(kind, slot, last);
    end
  end

  // Holds the receiver off for a number of cycles, counted here on its own.
  task automatic hold_receiver(int cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  // Offers one item and returns at the edge where it transfers. It is called just as
  // the previous item transfers or reset ends, so valid is only lowered when an idle
  // gap is drawn, and items with no gap between them keep valid high with a new payload.
  task automatic send_item(logic [1:0] op_v, logic [15:0] elapsed_v, logic [23:0] first_v,
                           logic [23:0] interval_v, logic loop_v, logic [3:0] slot_v);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_v;
    elapsed_ms <= elapsed_v;
    first_delay_ms <= first_v;
    interval_ms <= interval_v;
    loop_flag <= loop_v;
    slot_id <= slot_v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly small delays and steps so that slots fire and free up often; now and then
  // full-width or extreme values so every bit of every field moves.
  function automatic logic [23:0] pick_delay();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) return 24'($urandom_range(0, 3000));
    if (sel < 90) return 24'($urandom);
    return ($urandom_range(1)) ? 24'hFF_FFFF : 24'd0;
  endfunction

  task automatic send_random_item();
    int sel;
    logic [1:0]  op_v;
    logic [15:0] elapsed_v;
    logic [3:0]  slot_v;
    sel = $urandom_range(99);
    if (sel < 40) op_v = OP_TICK;
    else if (sel < 75) op_v = OP_SET;
    else if (sel < 95) op_v = OP_CANCEL;
    else op_v = OP_UNUSED;
    sel = $urandom_range(99);
    if (sel < 70) elapsed_v = 16'($urandom_range(0, 1500));
    else if (sel < 90) elapsed_v = 16'($urandom);
    else elapsed_v = ($urandom_range(1)) ? 16'hFFFF : 16'd0;
    slot_v = 4'($urandom_range(0, 15));
    send_item(op_v, elapsed_v, pick_delay(), pick_delay(), 1'($urandom_range(1)), slot_v);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. An empty bank answers a tick with the done marker alone, ignores
    // the unused code and reports a cancel of a free slot as missing.
    send_item(OP_TICK, 16'd0, 24'd0, 24'd0, 1'b0, 4'd0);
    send_item(OP_UNUSED, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 4'd15);
    send_item(OP_CANCEL, 16'd0, 24'd0, 24'd0, 1'b0, 4'd5);
    // A one-shot with zero delay fires on the very next tick, even one of zero time.
    send_item(OP_SET, 16'd0, 24'd0, 24'd0, 1'b0, 4'd0);
    send_item(OP_TICK, 16'd0, 24'd0, 24'd0, 1'b0, 4'd0);
    // Slot 0 gets the longest delay and interval; slot 1 loops with no interval at all,
    // so it stays due and fires once on every tick.
    send_item(OP_SET, 16'd0, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 4'd0);
    send_item(OP_SET, 16'd0, 24'd0, 24'd0, 1'b1, 4'd0);
    send_item(OP_TICK, 16'hFFFF, 24'd0, 24'd0, 1'b0, 4'd0);

    // A few more ticks at the largest step; the zero-interval slot keeps sinking and
    // fires on each of them while slot 0 counts down.
    for (int n = 0; n < REPEAT_TICKS; n++) begin
      send_item(OP_TICK, 16'hFFFF, 24'($urandom), 24'($urandom), 1'($urandom_range(1)),
                4'($urandom_range(0, 15)));
    end

    // Fill the remaining slots, then one more set finds the bank full.
    for (int n = 0; n < SLOT_COUNT - 1; n++) begin
      send_item(OP_SET, 16'($urandom), 24'($urandom_range(0, 5000)),
                24'($urandom_range(0, 5000)), 1'($urandom_range(1)), 4'($urandom));
    end
    send_item(OP_CANCEL, 16'd0, 24'd0, 24'd0, 1'b0, 4'd15);
    send_item(OP_CANCEL, 16'd0, 24'd0, 24'd0, 1'b0, 4'd15);

    // Random part in four idling phases. The first phase has no idling except for a
    // long receiver hold-off at its start, during which the sender keeps offering
    // items until the bank stops taking them.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct = 15;
          stall_pct = 15;
        end
      endcase
      if (p == 0) begin
        fork
          hold_receiver(300);
        join_none
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
    in_valid <= 1'b0;

    // Wait for every result still due, then let the block settle so that a stray
    // extra result would still be caught.
    while (bank.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (bank.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== timer_slot_bank_top.f =====
rtl/tsb_pkg.sv
rtl/tsb_ram.sv
rtl/tsb_alu.sv
rtl/timer_slot_bank_top.sv
tb/sv/tsb_tracker_pkg.sv
tb/sv/tb_timer_slot_bank_top.sv
